/* rtl/fat_cluster_chain_manager_top_assert.svh */
// ----------------------------------------------------------------------------
// fat cluster chain manager assertion macros
// immediate-implication and next-cycle forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_CHAIN_MANAGER_TOP_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_MANAGER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FCCM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FCCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fccm_pkg.sv */
// ----------------------------------------------------------------------------
// fccm_pkg
// shared constants and codes of the cluster chain manager
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam int ENTRIES   = 4096;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int BIT_W     = $clog2(ADDR_W);
  localparam int CLUSTER_W = 28;
  localparam int VALUE_W   = 32;
  localparam int LIMIT_W   = 13;

  // cluster_limit reset value, already clipped to the table size
  localparam int LIMIT_RESET = (ENTRIES < 4096) ? ENTRIES : 4096;

  localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 28'hFFF_FFF8;
  localparam logic [VALUE_W-1:0]   MARK_LAST    = 32'h0FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_NEXT  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

endpackage

/* rtl/fccm_ram.sv */
// ----------------------------------------------------------------------------
// fccm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fccm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fat_cluster_chain_manager_top.sv */
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_top
// fat32 style allocation table with next, set, next-fit alloc and chain free
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  command   | start, busy            | cmd, cluster, entry_value
//  result    | done (one-cycle pulse) | result_cluster, status
//  config    | cfg_wr_en              | cfg_wr_data (cluster_limit)
//
// flow: set and a next or alloc reject finish from idle; next reads the entry; alloc
//   takes hint modulo span, one bit a cycle, then reads and checks each candidate;
//   free checks and clears each link; the single table read port sets the probe rate
// reset: a clearing pass writes zero to all 4096 entries, one per cycle,
//   with busy high; config writes are taken during the pass
// accept on start high and busy low; results cannot be held off, no stalls
//
module fat_cluster_chain_manager_top
  import fccm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [CLUSTER_W-1:0] cluster,
  input  logic [VALUE_W-1:0]   entry_value,
  output logic                 done,
  output logic [CLUSTER_W-1:0] result_cluster,
  output logic [1:0]           status,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_FETCH     = 8'b0000_0100,
    S_MOD       = 8'b0000_1000,
    S_ALLOC_RD  = 8'b0001_0000,
    S_ALLOC_CHK = 8'b0010_0000,
    S_FREE_CHK  = 8'b0100_0000,
    S_FREE_RD   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // effective limit, min(cluster_limit, table size)
  logic [CNT_W-1:0]     eff_lim;
  logic [ADDR_W-1:0]    hint, hint_next;
  logic [ADDR_W-1:0]    clr_addr, clr_addr_next;

  // modulo unit and next-fit walk
  logic [CNT_W-1:0]     rem, rem_next;
  logic [BIT_W-1:0]     bit_idx, bit_idx_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic [CNT_W-1:0]     tries, tries_next;

  // chain walk
  logic [CLUSTER_W-1:0] cur, cur_next;
  logic [CNT_W-1:0]     steps, steps_next;

  // table port
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [VALUE_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  // finishing item
  logic                 fin;
  logic [CLUSTER_W-1:0] fin_cluster;
  status_t              fin_status;

  logic [CNT_W-1:0]     span;
  logic [CNT_W-1:0]     span_m1;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [ADDR_W-1:0]    cand_addr;
  logic                 in_range;
  logic                 cur_end;

  fccm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign span      = eff_lim - CNT_W'(2);
  assign span_m1   = span - CNT_W'(1);
  assign in_range  = (cluster < CLUSTER_W'(eff_lim));
  assign cand_addr = ADDR_W'(idx + CNT_W'(2));
  assign cur_end   = (cur < CLUSTER_W'(2)) || (cur >= END_OF_CHAIN);

  // subtract-compare step of the restoring modulo
  assign trial    = {rem, hint[bit_idx]};
  assign trial_ge = (trial >= {1'b0, span});

  always_comb begin
    state_next    = state;
    hint_next     = hint;
    clr_addr_next = clr_addr;
    rem_next      = rem;
    bit_idx_next  = bit_idx;
    idx_next      = idx;
    tries_next    = tries;
    cur_next      = cur;
    steps_next    = steps;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr;
    ram_wdata     = '0;
    ram_raddr     = '0;
    fin           = 1'b0;
    fin_cluster   = '0;
    fin_status    = ST_OK;

    unique case (state)
      S_CLEAR: begin
        // post-reset sweep, every cluster free
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        ram_raddr = cluster[ADDR_W-1:0];
        if (start) begin
          unique case (cmd_t'(cmd))
            CMD_NEXT: begin
              if (in_range) begin
                state_next = S_FETCH;
              end else begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            CMD_SET: begin
              fin = 1'b1;
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = cluster[ADDR_W-1:0];
                ram_wdata = entry_value;
              end else begin
                fin_status = ST_RANGE;
              end
            end
            CMD_ALLOC: begin
              if (eff_lim <= CNT_W'(2)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                rem_next     = '0;
                bit_idx_next = BIT_W'(ADDR_W - 1);
                state_next   = S_MOD;
              end
            end
            CMD_FREE: begin
              cur_next   = cluster;
              steps_next = '0;
              state_next = S_FREE_CHK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_FETCH: begin
        fin         = 1'b1;
        fin_cluster = ram_rdata[CLUSTER_W-1:0];
      end

      S_MOD: begin
        // hint mod span, one hint bit per cycle, msb first
        rem_next     = trial_ge ? CNT_W'(trial - {1'b0, span}) : trial[CNT_W-1:0];
        bit_idx_next = bit_idx - BIT_W'(1);
        if (bit_idx == '0) begin
          idx_next   = rem_next;
          tries_next = '0;
          state_next = S_ALLOC_RD;
        end
      end

      S_ALLOC_RD: begin
        ram_raddr  = cand_addr;
        state_next = S_ALLOC_CHK;
      end

      S_ALLOC_CHK: begin
        if (ram_rdata == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = cand_addr;
          ram_wdata   = MARK_LAST;
          hint_next   = cand_addr;
          fin         = 1'b1;
          fin_cluster = CLUSTER_W'(cand_addr);
          state_next  = S_IDLE;
        end else if (tries == span_m1) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          tries_next = tries + CNT_W'(1);
          idx_next   = (idx == span_m1) ? '0 : idx + CNT_W'(1);
          state_next = S_ALLOC_RD;
        end
      end

      S_FREE_CHK: begin
        ram_raddr = cur[ADDR_W-1:0];
        if (cur_end) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (cur >= CLUSTER_W'(eff_lim)) begin
          fin        = 1'b1;
          fin_status = ST_RANGE;
          state_next = S_IDLE;
        end else if (steps >= eff_lim) begin
          fin        = 1'b1;
          fin_status = ST_LONG;
          state_next = S_IDLE;
        end else begin
          state_next = S_FREE_RD;
        end
      end

      S_FREE_RD: begin
        // link read last cycle, clear the entry and follow it
        ram_we     = 1'b1;
        ram_waddr  = cur[ADDR_W-1:0];
        ram_wdata  = '0;
        cur_next   = ram_rdata[CLUSTER_W-1:0];
        steps_next = steps + CNT_W'(1);
        state_next = S_FREE_CHK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (state == S_FETCH) begin
      state_next = S_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hint     <= ADDR_W'(2);
      eff_lim  <= CNT_W'(LIMIT_RESET);
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      hint     <= hint_next;
      done     <= fin;
      if (cfg_wr_en) begin
        eff_lim <= (CLUSTER_W'(cfg_wr_data) < CLUSTER_W'(ENTRIES)) ?
                   CNT_W'(cfg_wr_data) : CNT_W'(ENTRIES);
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    rem     <= rem_next;
    bit_idx <= bit_idx_next;
    idx     <= idx_next;
    tries   <= tries_next;
    cur     <= cur_next;
    steps   <= steps_next;
    if (fin) begin
      result_cluster <= fin_cluster;
      status         <= fin_status;
    end
  end

endmodule

/* rtl/fccm_checker.sv */
// ----------------------------------------------------------------------------
// fccm_checker
// port-level checks of the cluster chain manager, bound to the top level
// ----------------------------------------------------------------------------
`include "fat_cluster_chain_manager_top_assert.svh"

module fccm_checker
  import fccm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [CLUSTER_W-1:0] result_cluster,
  input logic [1:0]           status
);

  // an accepted item either finishes next cycle or keeps the block busy
  `FCCM_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, done || busy, "accepted item stalled with no result")

  // a failed item never reports a cluster
  `FCCM_ASSERT_SAME(a_fail_zero, clk, rst, done && (status != ST_OK), result_cluster == '0, "nonzero cluster on failure")

  // a result only follows an accepted item or work in progress
  `FCCM_ASSERT_SAME(a_done_cause, clk, rst, done, $past(busy) || $past(start), "result with no item")

  // an idle block with no command stays quiet
  `FCCM_ASSERT_NEXT(a_idle_quiet, clk, rst, !busy && !start, !done, "spurious result strobe")

endmodule

bind fat_cluster_chain_manager_top fccm_checker u_fccm_checker (.*);
